// ===== src/ssf_pkg.sv =====
`timescale 1ns / 1ps

package ssf_pkg;

  localparam int TAP_COUNT_DEF   = 26;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COEF_BITS_DEF   = 16;

  localparam int ROM_TAPS = 26;

  // Register map of the configuration port.
  localparam int REG_IDX_BITS  = 2;
  localparam int REG_DATA_BITS = 16;
  localparam logic [REG_IDX_BITS-1:0] REG_FILTER_MODE      = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_SMOOTHING_WEIGHT = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_SAMPLE_LIMIT     = 2'd2;

  // Filter modes; the unused code behaves as passthrough.
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_SMOOTH = 2'd1;
  localparam logic [1:0] MODE_FIR    = 2'd2;

  localparam logic [15:0] WEIGHT_RESET = 16'd32768;

  // Low-pass taps in Q1.15, symmetric.
  localparam logic signed [15:0] COEF_ROM [ROM_TAPS] = '{
    -16'sd220, -16'sd311, -16'sd354, -16'sd311, -16'sd141, 16'sd184, 16'sd665,
    16'sd1281, 16'sd1982, 16'sd2694, 16'sd3326, 16'sd3804, 16'sd4063,
    16'sd4063, 16'sd3804, 16'sd3326, 16'sd2694, 16'sd1982, 16'sd1281,
    16'sd665, 16'sd184, -16'sd141, -16'sd311, -16'sd354, -16'sd311, -16'sd220
  };

  typedef struct packed {
    logic shift;
    logic clear;
  } shift_ctl_t;

  // Tap coefficient rescaled to Q1.(cbits-1); narrower formats round half up.
  function automatic logic signed [31:0] tap_coef(int idx, int cbits);
    logic signed [31:0] c;
    logic signed [31:0] t;
    if (idx >= ROM_TAPS) begin
      return 32'sd0;
    end
    c = 32'(COEF_ROM[idx]);
    if (cbits >= 16) begin
      return c <<< (cbits - 16);
    end
    t = c + (32'sd1 <<< (15 - cbits));
    return t >>> (16 - cbits);
  endfunction

endpackage

// ===== src/ssf_in_if.sv =====
`timescale 1ns / 1ps

interface ssf_in_if #(
  parameter int SAMPLE_BITS = ssf_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic                   restart;

  modport source (output valid, output sample_in, output restart, input ready);
  modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

// ===== src/ssf_out_if.sv =====
`timescale 1ns / 1ps

interface ssf_out_if #(
  parameter int SAMPLE_BITS = ssf_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] filtered_out;
  logic [15:0]            sample_index;
  logic                   run_done;

  modport source (output valid, output filtered_out, output sample_index,
                  output run_done, input ready);
  modport sink   (input valid, input filtered_out, input sample_index,
                  input run_done, output ready);
endinterface

// ===== src/selectable_sample_filter_top.sv =====
`timescale 1ns / 1ps

// Each accepted word sends the partial sum once along the chain of tap cells
// (one cell per cycle), then passes the capture and delivery steps; a new word
// is taken only in idle, after the last result has been delivered, and a result
// left waiting at the output adds its wait.
// Reset (synchronous, active high) zeroes the history, smoother and count,
// and loads the register reset values; the block is ready the cycle after.
module selectable_sample_filter_top #(
  parameter int TAP_COUNT   = ssf_pkg::TAP_COUNT_DEF,
  parameter int SAMPLE_BITS = ssf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = ssf_pkg::COEF_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ssf_pkg::REG_IDX_BITS-1:0]   cfg_index,
  input  logic [ssf_pkg::REG_DATA_BITS-1:0]  cfg_data,
  ssf_in_if.sink                             in_ch,
  ssf_out_if.source                          out_ch
);

  localparam int ACC_W = COEF_BITS + SAMPLE_BITS + 1 + $clog2(TAP_COUNT);
  localparam int SM_W  = SAMPLE_BITS + 18;
  localparam logic [SAMPLE_BITS-1:0]  SAMPLE_MAX = '1;
  localparam logic signed [ACC_W-1:0] FIR_HALF   = ACC_W'(1) << (COEF_BITS - 2);
  localparam logic signed [ACC_W-1:0] FIR_MAX    = ACC_W'(SAMPLE_MAX);

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_DELIVER} state_t;

  state_t state;

  logic [1:0]  filter_mode;
  logic [15:0] smoothing_weight;
  logic [15:0] sample_limit;

  logic [SAMPLE_BITS-1:0] smoothed_value;
  logic [15:0]            sample_count;

  logic [1:0]             mode_q;
  logic [SAMPLE_BITS-1:0] x_q;
  logic [15:0]            idx_q;
  logic                   done_q;
  logic [SAMPLE_BITS-1:0] y_q;
  logic                   start;

  logic signed [SAMPLE_BITS:0] sm_diff;
  logic signed [SM_W-1:0]      sm_prod;

  logic [SAMPLE_BITS-1:0] out_y;
  logic [15:0]            out_idx;
  logic                   out_done;
  logic                   out_valid;

  logic accept;
  logic [15:0] cnt_base;
  logic [15:0] cnt_inc;
  logic        cnt_hit;
  logic [SAMPLE_BITS-1:0] y_prev;

  logic [SAMPLE_BITS-1:0]  taps   [TAP_COUNT];
  logic                    go_vec [TAP_COUNT];
  logic signed [ACC_W-1:0] sums   [TAP_COUNT];
  logic [TAP_COUNT-1:0]    go_bits;
  logic                    go_last;

  logic signed [ACC_W-1:0] fir_round;
  logic signed [ACC_W-1:0] fir_shift;
  logic [SAMPLE_BITS-1:0]  y_fir;
  logic signed [SM_W-1:0]  sm_acc;
  logic [SAMPLE_BITS+1:0]  sm_hi;
  logic [SAMPLE_BITS-1:0]  y_sm;
  logic [SAMPLE_BITS-1:0]  y_sel;

  assign in_ch.ready         = (state == ST_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.filtered_out = out_y;
  assign out_ch.sample_index = out_idx;
  assign out_ch.run_done     = out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode      <= ssf_pkg::MODE_PASS;
      smoothing_weight <= ssf_pkg::WEIGHT_RESET;
      sample_limit     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ssf_pkg::REG_FILTER_MODE:      filter_mode      <= cfg_data[1:0];
        ssf_pkg::REG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data;
        ssf_pkg::REG_SAMPLE_LIMIT:     sample_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tap chain: history shifts in on accept, then one sum wave runs along it.
  generate
    for (genvar i = 0; i < TAP_COUNT; i++) begin : g_tap
      localparam logic signed [31:0] CI = ssf_pkg::tap_coef(i, COEF_BITS);
      ssf_pkg::shift_ctl_t     ctl;
      logic [SAMPLE_BITS-1:0]  prev;
      logic                    gi;
      logic signed [ACC_W-1:0] si;

      assign ctl.shift = accept;
      if (i == 0) begin : g_head
        assign ctl.clear = 1'b0;
        assign prev      = in_ch.sample_in;
        assign gi        = start;
        assign si        = '0;
      end else begin : g_body
        assign ctl.clear = in_ch.restart;
        assign prev      = taps[i-1];
        assign gi        = go_vec[i-1];
        assign si        = sums[i-1];
      end

      ssf_tap_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .ACC_W       (ACC_W),
        .COEF        (CI[COEF_BITS-1:0])
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .sample_prev (prev),
        .sample      (taps[i]),
        .go_in       (gi),
        .sum_in      (si),
        .go_out      (go_vec[i]),
        .sum_out     (sums[i])
      );

      assign go_bits[i] = go_vec[i];
    end
  endgenerate

  assign go_last = go_vec[TAP_COUNT-1];

  always_comb begin
    cnt_base = in_ch.restart ? 16'd0 : sample_count;
    cnt_inc  = cnt_base + 16'd1;
    cnt_hit  = (sample_limit != 16'd0) && (cnt_inc == sample_limit);
    y_prev   = in_ch.restart ? '0 : smoothed_value;
  end

  // Smoother as a*(y - x) + x*2^16, one registered multiply.
  always_ff @(posedge clk) begin
    if (accept) begin
      sm_diff <= $signed({1'b0, y_prev}) - $signed({1'b0, in_ch.sample_in});
    end
    sm_prod <= SM_W'($signed({1'b0, smoothing_weight})) * SM_W'(sm_diff);
  end

  always_comb begin
    fir_round = sums[TAP_COUNT-1] + FIR_HALF;
    fir_shift = fir_round >>> (COEF_BITS - 1);
    if (fir_round < 0) begin
      y_fir = '0;
    end else if (fir_shift > FIR_MAX) begin
      y_fir = SAMPLE_MAX;
    end else begin
      y_fir = fir_shift[SAMPLE_BITS-1:0];
    end

    sm_acc = sm_prod + SM_W'({x_q, 16'b0}) + SM_W'(32768);
    sm_hi  = sm_acc[SM_W-1:16];
    if (sm_hi[SAMPLE_BITS+1]) begin
      y_sm = '0;
    end else if (sm_hi[SAMPLE_BITS]) begin
      y_sm = SAMPLE_MAX;
    end else begin
      y_sm = sm_hi[SAMPLE_BITS-1:0];
    end

    case (mode_q)
      ssf_pkg::MODE_SMOOTH: y_sel = y_sm;
      ssf_pkg::MODE_FIR:    y_sel = y_fir;
      default:              y_sel = x_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      start          <= 1'b0;
      out_valid      <= 1'b0;
      smoothed_value <= '0;
      sample_count   <= '0;
    end else begin
      start <= accept;
      // In the delivery step the output register is either refilled or held.
      if (out_valid && out_ch.ready && state != ST_DELIVER) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            mode_q       <= filter_mode;
            x_q          <= in_ch.sample_in;
            idx_q        <= cnt_inc;
            done_q       <= cnt_hit;
            sample_count <= cnt_hit ? 16'd0 : cnt_inc;
            if (in_ch.restart) begin
              smoothed_value <= '0;
            end
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (go_last) begin
            y_q <= y_sel;
            if (mode_q == ssf_pkg::MODE_SMOOTH) begin
              smoothed_value <= y_sm;
            end
            state <= ST_DELIVER;
          end
        end
        ST_DELIVER: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_y     <= y_q;
            out_idx   <= idx_q;
            out_done  <= done_q;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_go_in_calc: assert property (@(posedge clk) disable iff (rst)
    go_last |-> state == ST_CALC)
    else $error("sum wave left the chain outside a calculation");

  a_one_wave: assert property (@(posedge clk) disable iff (rst)
    $countones(go_bits) <= 1)
    else $error("more than one sum wave in the tap chain");

  a_out_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DELIVER))
    else $error("result word appeared without a delivery step");

endmodule

// ===== src/ssf_tap_cell.sv =====
`timescale 1ns / 1ps

module ssf_tap_cell #(
  parameter int SAMPLE_BITS = ssf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = ssf_pkg::COEF_BITS_DEF,
  parameter int ACC_W       = 40,
  parameter logic signed [COEF_BITS-1:0] COEF = '0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ssf_pkg::shift_ctl_t      ctl,
  input  logic [SAMPLE_BITS-1:0]   sample_prev,
  output logic [SAMPLE_BITS-1:0]   sample,
  input  logic                     go_in,
  input  logic signed [ACC_W-1:0]  sum_in,
  output logic                     go_out,
  output logic signed [ACC_W-1:0]  sum_out
);

  localparam int PW = COEF_BITS + SAMPLE_BITS + 1;

  logic signed [PW-1:0] prod;

  assign prod = PW'(COEF) * PW'($signed({1'b0, sample}));

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
      go_out <= 1'b0;
    end else begin
      if (ctl.shift) begin
        sample <= ctl.clear ? '0 : sample_prev;
      end
      go_out <= go_in;
    end
  end

  // The partial sum walks one cell per cycle together with the go marker.
  always_ff @(posedge clk) begin
    if (go_in) begin
      sum_out <= sum_in + ACC_W'(prod);
    end
  end

endmodule
